FILE: hdl/mfau_pkg.sv
// ----------------------------------------------------------------------------
// mfau_pkg
// Shared types and constants for the motor feedback angle unwrap block.
// ----------------------------------------------------------------------------
package mfau_pkg;

  localparam logic [10:0] FirstId = 11'h205;

  localparam int AngleW  = 16;
  localparam int StepW   = 18;
  localparam int AccW    = 40;
  localparam int TotalW  = 48;
  localparam int VelW    = 33;
  localparam int ScaleW  = 16;
  localparam int SlotW   = 3;
  localparam int InDataW = 104;
  localparam int OutDataW = 176;

  localparam logic CfgAngleScale    = 1'b0;
  localparam logic CfgVelocityScale = 1'b1;

  typedef struct packed {
    logic [SlotW-1:0]         slot;
    logic [1:0]               motor_index;
    logic [AngleW-1:0]        angle_raw;
    logic signed [15:0]       rpm_raw;
    logic signed [15:0]       current_raw;
    logic [7:0]               temperature_raw;
    logic [31:0]              update_time;
  } word_t;

  typedef struct packed {
    logic [ScaleW-1:0] angle_scale;
    logic [ScaleW-1:0] velocity_scale;
  } cfg_t;

endpackage

FILE: hdl/motor_feedback_angle_unwrap.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_unwrap
// Decodes motor feedback frames into multi-turn angle and velocity.
// ----------------------------------------------------------------------------
// Queued words pass s1, s2 and the output register in turn; frames outside
// the motor identifier window are consumed without a result. Throughput is one
// word per cycle while the output is not stalled, set by the per-motor unwrap
// and accumulate step at the head of the back end; a two-entry queue lets the
// input keep flowing while a result waits on the output. Writes to the scale
// registers must be made only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module motor_feedback_angle_unwrap import mfau_pkg::*; #(
  parameter int MOTORS         = 4,
  parameter int TICKS_PER_TURN = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [ScaleW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // frame_id, angle_high, angle_low, speed_high, speed_low, current_high,
  // current_low, temperature_byte, now_time
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // motor_index, angle_raw, rpm_raw, current_raw, temperature_raw,
  // total_angle, velocity, update_time
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t  cfg_q;
  logic  q_push, q_full, q_pop, q_empty;
  word_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_scale    <= 16'd150;
      cfg_q.velocity_scale <= 16'd20480;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAngleScale:    cfg_q.angle_scale    <= cfg_wdata_i;
        CfgVelocityScale: cfg_q.velocity_scale <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mfau_front #(
    .Motors (MOTORS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_word_o      (q_in)
  );

  mfau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .word_o  (q_out)
  );

  mfau_back #(
    .Motors       (MOTORS),
    .TicksPerTurn (TICKS_PER_TURN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_word_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: hdl/mfau_front.sv
// ----------------------------------------------------------------------------
// mfau_front
// Accepts feedback frames, drops identifiers outside the motor window and
// unpacks the data bytes into a queue word.
// ----------------------------------------------------------------------------
module mfau_front import mfau_pkg::*; #(
  parameter int Motors = 4
) (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               q_full_i,
  output logic               q_push_o,
  output word_t              q_word_o
);

  logic [10:0] frame_id;
  logic [10:0] id_off;
  logic        in_window;

  assign frame_id  = s_axis_tdata[10:0];
  assign id_off    = frame_id - FirstId;
  assign in_window = (frame_id >= FirstId) && (id_off < 11'(Motors));

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && in_window;

  always_comb begin
    q_word_o.slot            = id_off[SlotW-1:0];
    q_word_o.motor_index     = id_off[1:0];
    q_word_o.angle_raw       = {s_axis_tdata[18:11], s_axis_tdata[26:19]};
    q_word_o.rpm_raw         = $signed({s_axis_tdata[34:27], s_axis_tdata[42:35]});
    q_word_o.current_raw     = $signed({s_axis_tdata[50:43], s_axis_tdata[58:51]});
    q_word_o.temperature_raw = s_axis_tdata[66:59];
    q_word_o.update_time     = s_axis_tdata[98:67];
  end

endmodule

FILE: hdl/mfau_queue.sv
// ----------------------------------------------------------------------------
// mfau_queue
// Two-entry queue between the frame front end and the update back end.
// ----------------------------------------------------------------------------
module mfau_queue import mfau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t word_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output word_t word_o
);

  word_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

FILE: hdl/mfau_back.sv
// ----------------------------------------------------------------------------
// mfau_back
// Per-motor unwrap and accumulate, split scaling multiplies and the output
// register.
// ----------------------------------------------------------------------------
module mfau_back import mfau_pkg::*; #(
  parameter int Motors       = 4,
  parameter int TicksPerTurn = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_empty_i,
  input  word_t               q_word_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int IdxW = (Motors > 1) ? $clog2(Motors) : 1;
  localparam logic signed [StepW-1:0] Turn = StepW'(TicksPerTurn);
  localparam logic signed [StepW-1:0] Half = StepW'(TicksPerTurn / 2);
  localparam logic signed [AccW-1:0]  AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0]  AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [TotalW-1:0] TotMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotMin = {1'b1, {(TotalW-1){1'b0}}};

  logic [AngleW-1:0]      last_angle_q [Motors];
  logic signed [AccW-1:0] tick_q       [Motors];

  logic                   adv;
  logic [IdxW-1:0]        idx;
  logic signed [StepW-1:0] diff, step;
  logic signed [AccW:0]   sum;
  logic signed [AccW-1:0] acc_d;

  logic                   s1_valid_q;
  word_t                  s1_word_q;
  logic signed [AccW-1:0] s1_acc_q;

  logic                   s2_valid_q;
  word_t                  s2_word_q;
  logic signed [37:0]     s2_plo_q, s2_plo_d;
  logic signed [36:0]     s2_phi_q, s2_phi_d;
  logic signed [VelW-1:0] s2_vel_q, s2_vel_d;

  logic signed [56:0]     total_full;
  logic signed [TotalW-1:0] total_d;

  logic                   out_valid_q;
  word_t                  out_word_q;
  logic signed [TotalW-1:0] out_total_q;
  logic signed [VelW-1:0] out_vel_q;

  assign adv     = !out_valid_q || m_axis_tready;
  assign q_pop_o = adv && !q_empty_i;
  assign idx     = q_word_i.slot[IdxW-1:0];

  // unwrap the step once, then accumulate with saturation
  always_comb begin
    diff = $signed({2'b00, q_word_i.angle_raw}) - $signed({2'b00, last_angle_q[idx]});
    if (diff < -Half) begin
      step = diff + Turn;
    end else if (diff > Half) begin
      step = diff - Turn;
    end else begin
      step = diff;
    end
    sum = {tick_q[idx][AccW-1], tick_q[idx]} + {{(AccW+1-StepW){step[StepW-1]}}, step};
    if (sum[AccW] != sum[AccW-1]) begin
      acc_d = sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_d = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Motors; i++) begin
        last_angle_q[i] <= '0;
        tick_q[i]       <= '0;
      end
    end else if (q_pop_o) begin
      last_angle_q[idx] <= q_word_i.angle_raw;
      tick_q[idx]       <= acc_d;
    end
  end

  // split the accumulator so each multiply stays narrow
  always_comb begin
    s2_plo_d = 38'($signed({1'b0, s1_acc_q[19:0]})) * 38'($signed({1'b0, cfg_i.angle_scale}));
    s2_phi_d = 37'($signed(s1_acc_q[AccW-1:20])) * 37'($signed({1'b0, cfg_i.angle_scale}));
    s2_vel_d = VelW'(s1_word_q.rpm_raw) * VelW'($signed({1'b0, cfg_i.velocity_scale}));
  end

  always_comb begin
    total_full = (57'(s2_phi_q) <<< 20) + 57'(s2_plo_q);
    if ((&total_full[56:TotalW-1]) || !(|total_full[56:TotalW-1])) begin
      total_d = total_full[TotalW-1:0];
    end else begin
      total_d = total_full[56] ? TotMin : TotMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_word_q   <= q_word_i;
      s1_acc_q    <= acc_d;
      s2_word_q   <= s1_word_q;
      s2_plo_q    <= s2_plo_d;
      s2_phi_q    <= s2_phi_d;
      s2_vel_q    <= s2_vel_d;
      out_word_q  <= s2_word_q;
      out_total_q <= total_d;
      out_vel_q   <= s2_vel_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0,
                          out_word_q.update_time,
                          out_vel_q,
                          out_total_q,
                          out_word_q.temperature_raw,
                          out_word_q.current_raw,
                          out_word_q.rpm_raw,
                          out_word_q.angle_raw,
                          out_word_q.motor_index};

endmodule

FILE: tb/angle_unwrap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_unwrap_checker
// Watches the frame, result and register ports of the angle unwrap block,
// predicts each motor update from its own copy of the per-motor angle and
// tick state, and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module angle_unwrap_checker import mfau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [ScaleW-1:0]   cfg_wdata_i,
  input  logic                frame_valid_i,
  input  logic                frame_ready_i,
  input  logic [InDataW-1:0]  frame_data_i,
  input  logic                result_valid_i,
  input  logic                result_ready_i,
  input  logic [OutDataW-1:0] result_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int     MotorCount   = 4;
  localparam int     TicksPerTurn = 8192;
  localparam int     HalfTurn     = TicksPerTurn / 2;
  localparam longint AccMax       = 64'sd549755813887;
  localparam longint AccMin       = -AccMax - 1;
  localparam longint TotalMax     = 64'sd140737488355327;
  localparam longint TotalMin     = -TotalMax - 1;

  typedef struct packed {
    logic [1:0]  motor_index;
    logic [15:0] angle_raw;
    logic [15:0] rpm_raw;
    logic [15:0] current_raw;
    logic [7:0]  temperature_raw;
    logic [47:0] total_angle;
    logic [32:0] velocity;
    logic [31:0] update_time;
  } motor_update_t;

  logic [ScaleW-1:0] angle_scale;
  logic [ScaleW-1:0] velocity_scale;
  logic [15:0]       last_angle [MotorCount];
  longint            tick_total [MotorCount];
  motor_update_t     update_q [$];
  motor_update_t     want;

  function automatic bit unwrap_frame(input logic [InDataW-1:0] w, output motor_update_t r);
    logic [10:0]        id;
    logic [1:0]         m;
    logic [15:0]        ang;
    logic signed [15:0] rpm;
    int                 step;
    longint             acc;
    longint             total;
    longint             vel;
    id = w[10:0];
    r  = '0;
    if (id < FirstId || id > FirstId + 11'd3) return 1'b0;
    m    = 2'(id - FirstId);
    ang  = {w[18:11], w[26:19]};
    rpm  = {w[34:27], w[42:35]};
    step = int'(ang) - int'(last_angle[m]);
    if (step < -HalfTurn) begin
      step += TicksPerTurn;
    end else if (step > HalfTurn) begin
      step -= TicksPerTurn;
    end
    acc = tick_total[m] + longint'(step);
    if (acc > AccMax) acc = AccMax;
    if (acc < AccMin) acc = AccMin;
    tick_total[m] = acc;
    last_angle[m] = ang;
    total = acc * longint'(angle_scale);
    if (total > TotalMax) total = TotalMax;
    if (total < TotalMin) total = TotalMin;
    vel = longint'(rpm) * longint'(velocity_scale);
    r.motor_index     = m;
    r.angle_raw       = ang;
    r.rpm_raw         = rpm;
    r.current_raw     = {w[50:43], w[58:51]};
    r.temperature_raw = w[66:59];
    r.total_angle     = total[47:0];
    r.velocity        = vel[32:0];
    r.update_time     = w[98:67];
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_scale    = 16'd150;
      velocity_scale = 16'd20480;
      for (int i = 0; i < MotorCount; i++) begin
        last_angle[i] = '0;
        tick_total[i] = 0;
      end
      update_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (update_q.size() == 0) begin
          $error("result word with no update due, motor_index %0d", result_data_i[1:0]);
          fail_count_o++;
        end else begin
          want = update_q.pop_front();
          check_field("motor_index", want.motor_index, result_data_i[1:0]);
          check_field("angle_raw", want.angle_raw, result_data_i[17:2]);
          check_field("rpm_raw", want.rpm_raw, result_data_i[33:18]);
          check_field("current_raw", want.current_raw, result_data_i[49:34]);
          check_field("temperature_raw", want.temperature_raw, result_data_i[57:50]);
          check_field("total_angle", want.total_angle, result_data_i[105:58]);
          check_field("velocity", want.velocity, result_data_i[138:106]);
          check_field("update_time", want.update_time, result_data_i[170:139]);
        end
      end
      if (frame_valid_i && frame_ready_i) begin
        if (unwrap_frame(frame_data_i, want)) update_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgAngleScale:    angle_scale    = cfg_wdata_i;
          CfgVelocityScale: velocity_scale = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = update_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives feedback frames and scale writes into the angle unwrap block.
// ----------------------------------------------------------------------------
// A directed set covers the identifier window edges, the wrap thresholds,
// angles above one turn and the raw field extremes. Two motors are then wound
// in opposite directions at full scale, followed by random phases under
// several scale settings with random gaps on both sides, a long output
// hold-off and a full drain in mid-phase.
// ----------------------------------------------------------------------------
module testbench;
  import mfau_pkg::*;

  localparam int HoldCycles    = 80;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;
  localparam int WindCycles    = 4;
  localparam int PhaseFrames   = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_index;
  logic [ScaleW-1:0]   cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  int                  fail_count;
  int                  pending;
  bit                  hold_req;
  bit                  steady;
  int                  stall_left;
  int                  idle_cycles;

  motor_feedback_angle_unwrap u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  angle_unwrap_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .frame_valid_i  (s_axis_tvalid),
    .frame_ready_i  (s_axis_tready),
    .frame_data_i   (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [InDataW-1:0] make_frame(input logic [10:0] id,
      input logic [15:0] angle, input logic [15:0] rpm, input logic [15:0] current,
      input logic [7:0] temp, input logic [31:0] stamp);
    return {5'b0, stamp, temp, current[7:0], current[15:8], rpm[7:0], rpm[15:8],
            angle[7:0], angle[15:8], id};
  endfunction

  function automatic logic [InDataW-1:0] random_frame();
    logic [10:0] id;
    logic [15:0] angle;
    if ($urandom_range(0, 9) < 8) begin
      id = FirstId + 11'($urandom_range(0, 3));
    end else begin
      id = 11'($urandom_range(0, 2047));
    end
    case ($urandom_range(0, 3))
      0, 1: angle = 16'($urandom_range(0, 8191));
      2:    angle = 16'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 4))
          0: angle = 16'd0;
          1: angle = 16'd4096;
          2: angle = 16'd8191;
          3: angle = 16'd8192;
          default: angle = 16'hFFFF;
        endcase
      end
    endcase
    return make_frame(id, angle, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      $urandom());
  endfunction

  task automatic push_frame(input logic [InDataW-1:0] d);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid, wait out every due update and any frame still in flight
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [ScaleW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_scales(input logic [ScaleW-1:0] angle_s,
                            input logic [ScaleW-1:0] vel_s);
    write_reg(CfgAngleScale, angle_s);
    write_reg(CfgVelocityScale, vel_s);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CfgAngleScale;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    steady        = 1'b0;
    idle_cycles   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_scales(16'd150, 16'd20480);
    push_frame(make_frame(11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1));
    push_frame(make_frame(11'h7FF, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0));
    push_frame(make_frame(FirstId - 11'd1, 16'd100, 16'd1, 16'd1, 8'd1, 32'd1));
    push_frame(make_frame(FirstId + 11'd4, 16'd100, 16'd1, 16'd1, 8'd1, 32'd2));
    push_frame(make_frame(FirstId, 16'd4096, 16'd10, 16'd20, 8'd30, 32'd3));
    push_frame(make_frame(FirstId, 16'd0, 16'd10, 16'd20, 8'd30, 32'd4));
    push_frame(make_frame(FirstId, 16'd4097, 16'd10, 16'd20, 8'd30, 32'd5));
    push_frame(make_frame(FirstId, 16'd0, 16'd10, 16'd20, 8'd30, 32'd6));
    push_frame(make_frame(FirstId + 11'd1, 16'hFFFF, 16'd5, 16'd6, 8'd7, 32'd7));
    push_frame(make_frame(FirstId + 11'd1, 16'd0, 16'd5, 16'd6, 8'd7, 32'd8));
    push_frame(make_frame(FirstId + 11'd1, 16'd8192, 16'd5, 16'd6, 8'd7, 32'd9));
    push_frame(make_frame(FirstId + 11'd2, 16'd8191, 16'h7FFF, 16'h8000, 8'hFF, '1));
    push_frame(make_frame(FirstId + 11'd3, 16'd0, 16'h8000, 16'h7FFF, 8'h00, '0));
    push_frame(make_frame(FirstId + 11'd2, 16'd8000, 16'hFFFF, 16'hFFFF, 8'h80, 32'd10));
    settle();

    // wind motor 2 up and motor 3 down at full scale
    set_scales(16'hFFFF, 16'hFFFF);
    steady = 1'b1;
    for (int c = 0; c < WindCycles; c++) begin
      for (int i = 0; i < 16; i++) begin
        push_frame(make_frame(FirstId + 11'd2, 16'(65535 - 4097 * i),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)), $urandom()));
        push_frame(make_frame(FirstId + 11'd3, 16'(4097 * i),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)), $urandom()));
      end
    end
    steady = 1'b0;
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_scales(16'd150, 16'd20480);
        1: set_scales(16'hFFFF, 16'hFFFF);
        2: set_scales(16'd0, 16'd0);
        3: set_scales(16'd1, 16'd1);
        default: set_scales(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      for (int n = 0; n < PhaseFrames; n++) begin
        if (p == 1 && n == 40) begin
          steady   = 1'b1;
          hold_req = 1'b1;
          repeat (24) push_frame(random_frame());
          steady   = 1'b0;
        end
        if (p == 3 && n == 90) settle();
        if (n % 60 == 30) steady = 1'b1;
        if (n % 60 == 45) steady = 1'b0;
        push_frame(random_frame());
      end
      steady = 1'b0;
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
